// ----- sv/eks_pkg.sv -----
// Package for the encoded key item splitter: widths, type codes, status codes,
// parse phases and the structs passed between the front, the beat queue and the back.
// Depends on nothing; the design files refer to it by scoped names, the testbench files import it.
package eks_pkg;

	// Key length limit and the widths that follow from it.
	localparam int unsigned KEY_MAX = 16384;
	localparam int unsigned POS_W   = 15;
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(KEY_MAX);

	// Reset value of the item select register: bit 14 set means every item.
	localparam logic [14:0] SEL_RESET = 15'd16384;

	// Depth of the queue between the front and the back.
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_AW    = 2;

	// Type codes that open an item.
	localparam logic [7:0] TC_MINKEY  = 8'd0;
	localparam logic [7:0] TC_NULL    = 8'd20;
	localparam logic [7:0] TC_NUMBER  = 8'd30;
	localparam logic [7:0] TC_STRING  = 8'd40;
	localparam logic [7:0] TC_OBJECT  = 8'd50;
	localparam logic [7:0] TC_POBJECT = 8'd51;
	localparam logic [7:0] TC_ARRAY   = 8'd60;
	localparam logic [7:0] TC_PARRAY  = 8'd61;
	localparam logic [7:0] TC_BINARY  = 8'd70;
	localparam logic [7:0] TC_OID     = 8'd80;
	localparam logic [7:0] TC_BOOL    = 8'd90;
	localparam logic [7:0] TC_DATE    = 8'd100;
	localparam logic [7:0] TC_MAXKEY  = 8'd255;

	// Escape byte that follows a zero inside a string.
	localparam logic [7:0] ESC_BYTE = 8'hFF;

	// Total item lengths of the fixed-size types.
	localparam logic [31:0] LEN_NUMBER = 32'd11;
	localparam logic [31:0] LEN_OID    = 32'd13;
	localparam logic [31:0] LEN_ARRAY  = 32'd5;
	localparam logic [31:0] LEN_BOOL   = 32'd2;

	// Bytes of the binary length field, less one.
	localparam logic [1:0] LEN_FIELD_LAST = 2'd3;

	// Status codes of a result record.
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_UNKNOWN = 3'd1;
	localparam logic [2:0] ST_UNTERM  = 3'd2;
	localparam logic [2:0] ST_TRUNC   = 3'd3;
	localparam logic [2:0] ST_ABSENT  = 3'd4;

	// Parse phase of the front.
	typedef enum logic [2:0] {
		PH_EXPECT,
		PH_BODY,
		PH_LEN,
		PH_STR,
		PH_SKIP
	} phase_t;

	// One item record.
	typedef struct packed {
		logic [13:0] index;
		logic [13:0] offset;
		logic [14:0] length;
		logic [7:0]  ctype;
	} rec_t;

	// Per-key parse state of the front.
	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic [13:0]      start;
		logic [13:0]      seen;
		phase_t           phase;
		logic [7:0]       ctype;
		logic [31:0]      remain;
		logic [1:0]       lcnt;
		logic             zpend;
		logic [2:0]       err;
		rec_t             err_rec;
	} fstate_t;

	// What one key byte produced: finished items, key end and error state.
	typedef struct packed {
		logic [1:0]     n;
		rec_t [1:0]     ev;
		logic           last;
		logic [2:0]     err;
		rec_t           err_rec;
	} beat_t;

	// One result record as it leaves the block.
	typedef struct packed {
		rec_t       rec;
		logic [2:0] status;
		logic       eok;
	} out_t;

endpackage

// ----- sv/encoded_key_item_splitter.sv -----
// Top level of the encoded key item splitter: item select register, front parser,
// beat queue and back record stage. Depends on eks_pkg, eks_front, eks_beat_queue, eks_back.
//
// Key bytes enter through a queue-like port: a byte beat is taken when push is high
// and full is low, with key_last set on the final byte of a key. One byte is taken
// every cycle while the queue between the parser and the record stage has room.
// Result records leave through a second queue-like port: while empty is low the
// oldest record is on the result ports, and pop takes it. The byte's records are
// written into the beat queue as the byte is taken, and the record stage registers
// them from the queue head into its output register. A byte may cause up to two records;
// the record stage sends one per cycle from its output register while the receiver
// pops. A byte that causes two records always follows one that causes none, so with
// pop held high the four-beat middle queue never fills and full rises only while the
// receiver stalls. Each key ends with exactly one record that has end_of_key set.
// item_select is written over the cfg channel, which is always ready; it must only
// be written while no key is in flight. Reset clears all parse state, empties both
// queues and sets item_select to report every item.
module encoded_key_item_splitter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  key_byte,
	input  logic        key_last,
	output logic        empty,
	input  logic        pop,
	output logic [13:0] item_index,
	output logic [13:0] item_offset,
	output logic [14:0] item_length,
	output logic [7:0]  item_type,
	output logic [2:0]  status,
	output logic        end_of_key,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [14:0] cfg_data
);

	logic [14:0]     sel_q;
	logic            in_fire;
	eks_pkg::beat_t  fr_beat;
	logic            fr_push;
	eks_pkg::beat_t  hd_beat;
	logic            hd_valid;
	logic            hd_pop;
	logic            q_full;
	logic            out_valid;
	logic            out_pop;
	eks_pkg::out_t   out_rec;

	// Handshakes.
	assign cfg_ready = 1'b1;
	assign full      = q_full;
	assign in_fire   = push && !q_full;
	assign empty     = !out_valid;
	assign out_pop   = pop && out_valid;

	// Item select register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= eks_pkg::SEL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			sel_q <= cfg_data;
		end
	end

	eks_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.key_byte  (key_byte),
		.key_last  (key_last),
		.beat      (fr_beat),
		.beat_push (fr_push)
	);

	eks_beat_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (fr_push),
		.wr_beat  (fr_beat),
		.rd_en    (hd_pop),
		.rd_beat  (hd_beat),
		.rd_valid (hd_valid),
		.q_full   (q_full)
	);

	eks_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_select (sel_q),
		.beat        (hd_beat),
		.beat_valid  (hd_valid),
		.beat_pop    (hd_pop),
		.out_pop     (out_pop),
		.out_valid   (out_valid),
		.out_rec     (out_rec)
	);

	// Result ports.
	assign item_index  = out_rec.rec.index;
	assign item_offset = out_rec.rec.offset;
	assign item_length = out_rec.rec.length;
	assign item_type   = out_rec.rec.ctype;
	assign status      = out_rec.status;
	assign end_of_key  = out_rec.eok;

endmodule

// ----- sv/eks_front.sv -----
// Front of the splitter: parses key bytes, tracks item boundaries and errors,
// and emits one beat per byte that finishes items or ends the key. Uses eks_pkg.
module eks_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_fire,
	input  logic [7:0]     key_byte,
	input  logic           key_last,
	output eks_pkg::beat_t beat,
	output logic           beat_push
);

	eks_pkg::fstate_t state_q;
	eks_pkg::fstate_t state_n;

	// Record of the item in progress with a given length.
	function automatic eks_pkg::rec_t mk_rec(eks_pkg::fstate_t st, logic [14:0] len);
		eks_pkg::rec_t r;
		r.index  = st.seen;
		r.offset = st.start;
		r.length = len;
		r.ctype  = st.ctype;
		return r;
	endfunction

	// State after an item is finished.
	function automatic eks_pkg::fstate_t after_fin(eks_pkg::fstate_t st);
		eks_pkg::fstate_t t;
		t       = st;
		t.seen  = st.seen + 14'd1;
		t.phase = eks_pkg::PH_EXPECT;
		return t;
	endfunction

	// State after an error: the rest of the key is skipped.
	function automatic eks_pkg::fstate_t raise_err(eks_pkg::fstate_t st, logic [2:0] code,
			logic [14:0] len);
		eks_pkg::fstate_t t;
		t         = st;
		t.err_rec = mk_rec(st, len);
		t.err     = code;
		t.phase   = eks_pkg::PH_SKIP;
		t.zpend   = 1'b0;
		return t;
	endfunction

	// Parse one byte against the current state.
	always_comb begin
		eks_pkg::fstate_t s;
		eks_pkg::rec_t [1:0] evs;
		logic [1:0] n;
		logic do_open;
		logic [1:0] lsel;

		s = state_q;
		evs = '0;
		n = 2'd0;
		do_open = 1'b0;
		lsel = '0;

		if (state_q.err != eks_pkg::ST_OK) begin
			s = state_q;
		end else if (state_q.pos == eks_pkg::POS_MAX) begin
			// Byte beyond the key length limit.
			if (s.phase == eks_pkg::PH_EXPECT) begin
				s.start = eks_pkg::POS_MAX[13:0];
				s.ctype = '0;
				s = raise_err(s, eks_pkg::ST_TRUNC, 15'd0);
			end else begin
				s = raise_err(s, eks_pkg::ST_TRUNC, s.pos - {1'b0, s.start});
			end
		end else begin
			// Advance the phase by one byte.
			unique case (s.phase)
				eks_pkg::PH_EXPECT: begin
					do_open = 1'b1;
				end
				eks_pkg::PH_BODY: begin
					s.remain = s.remain - 32'd1;
					if (s.remain == 32'd0) begin
						evs[n[0]] = mk_rec(s, s.pos - {1'b0, s.start} + 15'd1);
						n = n + 2'd1;
						s = after_fin(s);
					end
				end
				eks_pkg::PH_LEN: begin
					lsel = s.lcnt;
					s.remain[{lsel, 3'b000} +: 8] = key_byte;
					s.lcnt = s.lcnt + 2'd1;
					if (lsel == eks_pkg::LEN_FIELD_LAST) begin
						if (s.remain != '1) begin
							s.remain = s.remain + 32'd1;
						end
						s.phase = eks_pkg::PH_BODY;
					end
				end
				eks_pkg::PH_STR: begin
					if (s.zpend) begin
						s.zpend = 1'b0;
						if (key_byte != eks_pkg::ESC_BYTE) begin
							evs[n[0]] = mk_rec(s, s.pos - {1'b0, s.start});
							n = n + 2'd1;
							s = after_fin(s);
							do_open = 1'b1;
						end
					end else if (key_byte == 8'd0) begin
						s.zpend = 1'b1;
					end
				end
				default: begin
					s = s;
				end
			endcase

			// A type code opens a new item.
			if (do_open) begin
				s.start = s.pos[13:0];
				s.ctype = key_byte;
				unique case (key_byte) inside
					eks_pkg::TC_MINKEY, eks_pkg::TC_NULL, eks_pkg::TC_OBJECT,
					eks_pkg::TC_MAXKEY: begin
						evs[n[0]] = mk_rec(s, 15'd1);
						n = n + 2'd1;
						s = after_fin(s);
					end
					eks_pkg::TC_NUMBER, eks_pkg::TC_DATE: begin
						s.remain = eks_pkg::LEN_NUMBER - 32'd1;
						s.phase  = eks_pkg::PH_BODY;
					end
					eks_pkg::TC_OID: begin
						s.remain = eks_pkg::LEN_OID - 32'd1;
						s.phase  = eks_pkg::PH_BODY;
					end
					eks_pkg::TC_ARRAY: begin
						s.remain = eks_pkg::LEN_ARRAY - 32'd1;
						s.phase  = eks_pkg::PH_BODY;
					end
					eks_pkg::TC_BOOL: begin
						s.remain = eks_pkg::LEN_BOOL - 32'd1;
						s.phase  = eks_pkg::PH_BODY;
					end
					eks_pkg::TC_STRING, eks_pkg::TC_POBJECT, eks_pkg::TC_PARRAY: begin
						s.phase = eks_pkg::PH_STR;
						s.zpend = 1'b0;
					end
					eks_pkg::TC_BINARY: begin
						s.phase  = eks_pkg::PH_LEN;
						s.remain = '0;
						s.lcnt   = '0;
					end
					default: begin
						s = raise_err(s, eks_pkg::ST_UNKNOWN, 15'd1);
					end
				endcase
			end

			// The key ends inside an item.
			if (key_last && s.err == eks_pkg::ST_OK && s.phase != eks_pkg::PH_EXPECT) begin
				if (s.phase == eks_pkg::PH_STR && s.zpend) begin
					evs[n[0]] = mk_rec(s, s.pos - {1'b0, s.start} + 15'd1);
					n = n + 2'd1;
					s = after_fin(s);
				end else if (s.phase == eks_pkg::PH_STR) begin
					s = raise_err(s, eks_pkg::ST_UNTERM, s.pos - {1'b0, s.start} + 15'd1);
				end else begin
					s = raise_err(s, eks_pkg::ST_TRUNC, s.pos - {1'b0, s.start} + 15'd1);
				end
			end
		end

		// Byte position saturates at the limit.
		if (state_q.pos != eks_pkg::POS_MAX) begin
			s.pos = state_q.pos + 15'd1;
		end

		// Beat toward the back, taken before the per-key clear.
		beat.n       = n;
		beat.ev      = evs;
		beat.last    = key_last;
		beat.err     = s.err;
		beat.err_rec = s.err_rec;
		beat_push    = in_fire && ((n != 2'd0) || key_last);

		if (key_last) begin
			state_n = '0;
		end else begin
			state_n = s;
		end
	end

	// Parse state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (in_fire) begin
			state_q <= state_n;
		end
	end

endmodule

// ----- sv/eks_beat_queue.sv -----
// Short queue of beats between the front and the back of the splitter.
// Depends on eks_pkg for the beat type and the queue depth.
module eks_beat_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  eks_pkg::beat_t wr_beat,
	input  logic           rd_en,
	output eks_pkg::beat_t rd_beat,
	output logic           rd_valid,
	output logic           q_full
);

	eks_pkg::beat_t              slot_q [eks_pkg::Q_DEPTH];
	logic [eks_pkg::Q_AW-1:0]    wr_ptr_q;
	logic [eks_pkg::Q_AW-1:0]    rd_ptr_q;
	logic [eks_pkg::Q_AW:0]      count_q;

	assign rd_beat  = slot_q[rd_ptr_q];
	assign rd_valid = (count_q != '0);
	assign q_full   = (count_q == (eks_pkg::Q_AW+1)'(eks_pkg::Q_DEPTH));

	// Beat storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_beat;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- sv/eks_back.sv -----
// Back of the splitter: turns beats into result records, holds the selected item
// in select mode, and drives the output register. Depends on eks_pkg.
module eks_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [14:0]    item_select,
	input  eks_pkg::beat_t beat,
	input  logic           beat_valid,
	output logic           beat_pop,
	input  logic           out_pop,
	output logic           out_valid,
	output eks_pkg::out_t  out_rec
);

	logic            out_v_q;
	eks_pkg::out_t   out_q;
	logic            held_v_q;
	eks_pkg::rec_t   held_q;
	logic            rec_idx_q;

	logic            every;
	logic            m0;
	logic            m1;
	logic            held_v_n;
	eks_pkg::rec_t   held_n;
	eks_pkg::out_t   recs [2];
	eks_pkg::out_t   none_rec;
	eks_pkg::out_t   err_out;
	logic [1:0]      cnt;
	logic            space;
	logic            last_rec;
	logic            load;

	assign out_valid = out_v_q;
	assign out_rec   = out_q;

	// Records that the head beat yields, and the held item after it.
	always_comb begin
		every = item_select[14];

		m0 = !every && !held_v_q && (beat.n != 2'd0) && (beat.ev[0].index == item_select[13:0]);
		m1 = !every && !held_v_q && (beat.n == 2'd2) && (beat.ev[1].index == item_select[13:0]);
		held_v_n = held_v_q || m0 || m1;
		if (m0) begin
			held_n = beat.ev[0];
		end else if (m1) begin
			held_n = beat.ev[1];
		end else begin
			held_n = held_q;
		end

		none_rec.rec.index  = item_select[13:0];
		none_rec.rec.offset = '0;
		none_rec.rec.length = '0;
		none_rec.rec.ctype  = '0;
		none_rec.status     = eks_pkg::ST_ABSENT;
		none_rec.eok        = 1'b1;

		err_out.rec    = beat.err_rec;
		err_out.status = beat.err;
		err_out.eok    = 1'b1;

		recs[0] = '{rec: beat.ev[0], status: eks_pkg::ST_OK, eok: 1'b0};
		recs[1] = '{rec: beat.ev[1], status: eks_pkg::ST_OK, eok: 1'b0};
		cnt = 2'd0;

		if (every) begin
			cnt = beat.n;
			if (beat.last) begin
				if (beat.err != eks_pkg::ST_OK) begin
					if (beat.n == 2'd0) begin
						recs[0] = err_out;
					end else begin
						recs[1] = err_out;
					end
					cnt = beat.n + 2'd1;
				end else if (beat.n == 2'd1) begin
					recs[0].eok = 1'b1;
				end else if (beat.n == 2'd2) begin
					recs[1].eok = 1'b1;
				end else begin
					recs[0] = none_rec;
					cnt = 2'd1;
				end
			end
		end else if (beat.last) begin
			cnt = 2'd1;
			if (held_v_n) begin
				recs[0] = '{rec: held_n, status: eks_pkg::ST_OK, eok: 1'b1};
			end else if (beat.err != eks_pkg::ST_OK) begin
				recs[0] = err_out;
			end else begin
				recs[0] = none_rec;
			end
		end

		space    = !out_v_q || out_pop;
		last_rec = (cnt == 2'd1) || rec_idx_q;
		load     = beat_valid && (cnt != 2'd0) && space;
		beat_pop = beat_valid && ((cnt == 2'd0) || (space && last_rec));
	end

	// Output record register.
	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= recs[rec_idx_q];
		end
	end

	// Output valid, record index within the beat, and the held item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q   <= 1'b0;
			rec_idx_q <= 1'b0;
			held_v_q  <= 1'b0;
		end else begin
			if (load) begin
				out_v_q   <= 1'b1;
				rec_idx_q <= !last_rec;
			end else if (out_pop) begin
				out_v_q <= 1'b0;
			end
			if (beat_pop) begin
				held_v_q <= beat.last ? 1'b0 : held_v_n;
			end
		end
	end

	// Held item payload.
	always_ff @(posedge clk) begin
		if (beat_pop) begin
			held_q <= held_n;
		end
	end

endmodule

// ----- tb/split_record_checker.sv -----
// Record checker for the encoded key item splitter: watches the key, config and record beats,
// predicts the records that each key byte causes and compares them as they leave.
// Depends on eks_pkg for the record types, type codes, status codes and parse phases.
module split_record_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [7:0]  key_byte,
	input  logic        key_last,
	input  logic        empty,
	input  logic        pop,
	input  logic [13:0] item_index,
	input  logic [13:0] item_offset,
	input  logic [14:0] item_length,
	input  logic [7:0]  item_type,
	input  logic [2:0]  status,
	input  logic        end_of_key,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [14:0] cfg_data,
	output int          fail_count,
	output int          open_records
);
	import eks_pkg::*;

	// Shadow of the item select register and the per-key parse state.
	logic [14:0] item_sel;
	int unsigned key_pos;
	int unsigned item_base;
	logic [13:0] items_done;
	phase_t      parse_phase;
	logic [7:0]  cur_type;
	logic [31:0] remain;
	int unsigned len_shift;
	bit          zero_pending;
	bit          held_ok;
	rec_t        held_rec;
	logic [2:0]  err_code;
	rec_t        err_rec;

	// Items finished by the current byte, and the records still due at the output.
	rec_t done_items[$];
	out_t pending_records[$];
	int   mismatches = 0;
	int   backlog = 0;

	assign fail_count   = mismatches;
	assign open_records = backlog;

	function automatic rec_t make_rec(logic [13:0] idx, int unsigned off, int unsigned len,
		logic [7:0] t);
		rec_t r;
		r.index  = idx;
		r.offset = off[13:0];
		r.length = len[14:0];
		r.ctype  = t;
		return r;
	endfunction

	function automatic void clear_key();
		key_pos      = 0;
		item_base    = 0;
		items_done   = '0;
		parse_phase  = PH_EXPECT;
		cur_type     = '0;
		remain       = '0;
		len_shift    = 0;
		zero_pending = 1'b0;
		held_ok      = 1'b0;
		held_rec     = '0;
		err_code     = ST_OK;
		err_rec      = '0;
	endfunction

	// Close the item in progress at byte end_pos.
	function automatic void finish_item(int unsigned end_pos);
		if (done_items.size() < 2)
			done_items.insert(done_items.size(),
				make_rec(items_done, item_base, end_pos - item_base + 1, cur_type));
		items_done  = items_done + 1'b1;
		parse_phase = PH_EXPECT;
	endfunction

	// Record an error; the rest of the key is skipped.
	function automatic void raise_err(logic [2:0] code, int unsigned len);
		err_rec      = make_rec(items_done, item_base, len, cur_type);
		err_code     = code;
		parse_phase  = PH_SKIP;
		zero_pending = 1'b0;
	endfunction

	// A type code byte fixes how the item body is measured.
	function automatic void open_item(logic [7:0] b, int unsigned p);
		item_base = p;
		cur_type  = b;
		case (b)
			TC_MINKEY, TC_NULL, TC_OBJECT, TC_MAXKEY: begin
				finish_item(p);
			end
			TC_NUMBER, TC_DATE: begin
				remain      = LEN_NUMBER - 1;
				parse_phase = PH_BODY;
			end
			TC_OID: begin
				remain      = LEN_OID - 1;
				parse_phase = PH_BODY;
			end
			TC_ARRAY: begin
				remain      = LEN_ARRAY - 1;
				parse_phase = PH_BODY;
			end
			TC_BOOL: begin
				remain      = LEN_BOOL - 1;
				parse_phase = PH_BODY;
			end
			TC_STRING, TC_POBJECT, TC_PARRAY: begin
				parse_phase  = PH_STR;
				zero_pending = 1'b0;
			end
			TC_BINARY: begin
				parse_phase = PH_LEN;
				remain      = '0;
				len_shift   = 0;
			end
			default: begin
				raise_err(ST_UNKNOWN, 1);
			end
		endcase
	endfunction

	// Advance the parse by one key byte and queue the records it causes.
	function automatic void parse_key_byte(logic [7:0] b, logic last);
		int unsigned p;
		bit          report_all;
		out_t        made[$];
		out_t        one;
		p          = key_pos;
		report_all = item_sel[14];
		done_items.delete();

		if (err_code != ST_OK) begin
			// Rest of the key is ignored after an error.
		end else if (p >= KEY_MAX) begin
			// Key too long: cut the item in progress, or report an empty item.
			if (parse_phase == PH_EXPECT) begin
				item_base = p;
				cur_type  = '0;
				raise_err(ST_TRUNC, 0);
			end else begin
				raise_err(ST_TRUNC, p - item_base);
			end
		end else begin
			case (parse_phase)
				PH_EXPECT: open_item(b, p);
				PH_BODY: begin
					remain = remain - 1;
					if (remain == 0)
						finish_item(p);
				end
				PH_LEN: begin
					// Binary length arrives little-endian; the body is one byte longer.
					remain    = remain | (32'(b) << (len_shift & 31));
					len_shift = len_shift + 8;
					if (len_shift >= 32) begin
						if (remain != '1)
							remain = remain + 1;
						parse_phase = PH_BODY;
					end
				end
				PH_STR: begin
					// A zero ends the string unless the escape byte follows it.
					if (zero_pending) begin
						zero_pending = 1'b0;
						if (b != ESC_BYTE) begin
							finish_item(p - 1);
							open_item(b, p);
						end
					end else if (b == 8'h00) begin
						zero_pending = 1'b1;
					end
				end
				default: ;
			endcase
			// Key end inside an item.
			if (last && err_code == ST_OK && parse_phase != PH_EXPECT) begin
				if (parse_phase == PH_STR && zero_pending)
					finish_item(p);
				else
					raise_err((parse_phase == PH_STR) ? ST_UNTERM : ST_TRUNC, p - item_base + 1);
			end
		end
		if (p < KEY_MAX)
			key_pos = p + 1;

		// Report finished items, or hold the selected one.
		foreach (done_items[i]) begin
			if (report_all) begin
				one.rec    = done_items[i];
				one.status = ST_OK;
				one.eok    = 1'b0;
				made.insert(made.size(), one);
			end else if (!held_ok && done_items[i].index == item_sel[13:0]) begin
				held_rec = done_items[i];
				held_ok  = 1'b1;
			end
		end

		// Each key closes with one record that has end_of_key set.
		if (last) begin
			if (report_all && err_code == ST_OK && made.size() > 0) begin
				made[made.size() - 1].eok = 1'b1;
			end else begin
				one.eok = 1'b1;
				if (!report_all && held_ok) begin
					one.rec    = held_rec;
					one.status = ST_OK;
				end else if (err_code != ST_OK) begin
					one.rec    = err_rec;
					one.status = err_code;
				end else begin
					one.rec    = make_rec(item_sel[13:0], 0, 0, 8'h00);
					one.status = ST_ABSENT;
				end
				made.insert(made.size(), one);
			end
			clear_key();
		end

		foreach (made[i])
			pending_records.insert(pending_records.size(), made[i]);
	endfunction

	function automatic void check_field(string what, logic [14:0] want, logic [14:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
			mismatches++;
		end
	endfunction

	// Compare one record beat with the oldest expectation.
	function automatic void check_record();
		out_t want;
		if (pending_records.size() == 0) begin
			$display({"%0t: unexpected record: index %0d offset %0d length %0d",
				" type %0d status %0d end %0d"},
				$time, item_index, item_offset, item_length, item_type, status, end_of_key);
			mismatches++;
		end else begin
			want = pending_records.pop_front();
			check_field("item_index", 15'(want.rec.index), 15'(item_index));
			check_field("item_offset", 15'(want.rec.offset), 15'(item_offset));
			check_field("item_length", want.rec.length, item_length);
			check_field("item_type", 15'(want.rec.ctype), 15'(item_type));
			check_field("status", 15'(want.status), 15'(status));
			check_field("end_of_key", 15'(want.eok), 15'(end_of_key));
		end
	endfunction

	// Sample every handshake at the rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_key();
			item_sel = SEL_RESET;
			pending_records.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				item_sel = cfg_data;
			if (push && !full)
				parse_key_byte(key_byte, key_last);
			if (pop && !empty)
				check_record();
		end
		backlog = pending_records.size();
	end

endmodule

// ----- tb/testbench.sv -----
// Top of the encoded key item splitter test: clock, reset, key and config stimulus, the
// record receiver and the verdict. Depends on eks_pkg, encoded_key_item_splitter and
// split_record_checker.
module testbench;
	import eks_pkg::*;

	localparam int RANDOM_BYTES  = 1020;
	localparam int PHASE_COUNT   = 6;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 200000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  key_byte = '0;
	logic        key_last = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [13:0] item_index;
	logic [13:0] item_offset;
	logic [14:0] item_length;
	logic [7:0]  item_type;
	logic [2:0]  status;
	logic        end_of_key;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [14:0] cfg_data = '0;
	int          fail_count;
	int          open_records;

	logic [7:0]  key_bytes[$];
	int          burst_left = 0;
	int          cycle_count = 0;
	logic [15:0] pop_mask = 16'hFFFF;
	logic [3:0]  pop_slot = '0;
	int          pop_hold = 0;

	always #2 clk = ~clk;

	encoded_key_item_splitter u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.key_byte   (key_byte),
		.key_last   (key_last),
		.empty      (empty),
		.pop        (pop),
		.item_index (item_index),
		.item_offset(item_offset),
		.item_length(item_length),
		.item_type  (item_type),
		.status     (status),
		.end_of_key (end_of_key),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	split_record_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.key_byte    (key_byte),
		.key_last    (key_last),
		.empty       (empty),
		.pop         (pop),
		.item_index  (item_index),
		.item_offset (item_offset),
		.item_length (item_length),
		.item_type   (item_type),
		.status      (status),
		.end_of_key  (end_of_key),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.open_records(open_records)
	);

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Receiver: a random stall mask, redrawn whenever its hold count runs out, sometimes all ones.
	always @(posedge clk) begin
		if (pop_hold == 0) begin
			pop_hold = $urandom_range(32, 256);
			pop_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
		end
		pop_hold = pop_hold - 1;
		pop <= pop_mask[pop_slot];
		pop_slot = pop_slot + 1'b1;
	end

	// Send one key byte beat; the sender runs in bursts with random gaps between them.
	task send_byte(input logic [7:0] b, input logic l);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 7);
			if (gap != 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		push     <= 1'b1;
		key_byte <= b;
		key_last <= l;
		@(posedge clk);
		while (full) @(posedge clk);
		burst_left = burst_left - 1;
	endtask

	task send_key();
		foreach (key_bytes[i])
			send_byte(key_bytes[i], i == key_bytes.size() - 1);
	endtask

	// Hold the sender until every expected record has left the block.
	task drain();
		push <= 1'b0;
		@(posedge clk);
		while (open_records != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	task write_select(input logic [14:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Append one well-formed item of a random type with random content.
	function automatic void append_item();
		logic [7:0]  code;
		logic [31:0] blen;
		case ($urandom_range(0, 12))
			0:       code = TC_MINKEY;
			1:       code = TC_NULL;
			2:       code = TC_NUMBER;
			3:       code = TC_STRING;
			4:       code = TC_OBJECT;
			5:       code = TC_POBJECT;
			6:       code = TC_ARRAY;
			7:       code = TC_PARRAY;
			8:       code = TC_BINARY;
			9:       code = TC_OID;
			10:      code = TC_BOOL;
			11:      code = TC_DATE;
			default: code = TC_MAXKEY;
		endcase
		key_bytes.insert(key_bytes.size(), code);
		case (code)
			TC_NUMBER, TC_DATE:
				repeat (LEN_NUMBER - 1) key_bytes.insert(key_bytes.size(), 8'($urandom()));
			TC_OID:
				repeat (LEN_OID - 1) key_bytes.insert(key_bytes.size(), 8'($urandom()));
			TC_ARRAY:
				repeat (LEN_ARRAY - 1) key_bytes.insert(key_bytes.size(), 8'($urandom()));
			TC_BOOL:
				repeat (LEN_BOOL - 1) key_bytes.insert(key_bytes.size(), 8'($urandom()));
			TC_BINARY: begin
				// Mostly short bodies; now and then one past 255 bytes.
				blen = ($urandom_range(0, 15) == 0) ? $urandom_range(256, 260) : $urandom_range(0, 5);
				for (int i = 0; i < 4; i++)
					key_bytes.insert(key_bytes.size(), blen[8*i +: 8]);
				repeat (blen + 1) key_bytes.insert(key_bytes.size(), 8'($urandom()));
			end
			TC_STRING, TC_POBJECT, TC_PARRAY: begin
				// Body with escaped zeros, closed by a plain zero.
				repeat ($urandom_range(0, 6)) begin
					if ($urandom_range(0, 4) == 0) begin
						key_bytes.insert(key_bytes.size(), 8'h00);
						key_bytes.insert(key_bytes.size(), ESC_BYTE);
					end else begin
						key_bytes.insert(key_bytes.size(), 8'($urandom_range(1, 255)));
					end
				end
				key_bytes.insert(key_bytes.size(), 8'h00);
			end
			default: ;
		endcase
	endfunction

	// Mostly well-formed keys; the rest are cut short, hit an unknown code,
	// leave a string open or are pure noise.
	function automatic void make_random_key();
		logic [7:0] code;
		int unsigned keep;
		key_bytes.delete();
		repeat ($urandom_range(1, 5)) append_item();
		case ($urandom_range(0, 9))
			0: begin
				if (key_bytes.size() > 1) begin
					keep = $urandom_range(1, key_bytes.size() - 1);
					while (key_bytes.size() > keep) void'(key_bytes.pop_back());
				end
			end
			1: begin
				do code = 8'($urandom()); while (code inside {TC_MINKEY, TC_NULL, TC_NUMBER,
					TC_STRING, TC_OBJECT, TC_POBJECT, TC_ARRAY, TC_PARRAY, TC_BINARY, TC_OID,
					TC_BOOL, TC_DATE, TC_MAXKEY});
				key_bytes.insert(key_bytes.size(), code);
				repeat ($urandom_range(0, 3)) key_bytes.insert(key_bytes.size(), 8'($urandom()));
			end
			2: begin
				key_bytes.insert(key_bytes.size(), TC_STRING);
				repeat ($urandom_range(0, 3))
					key_bytes.insert(key_bytes.size(), 8'($urandom_range(1, 255)));
			end
			3: begin
				key_bytes.delete();
				repeat ($urandom_range(1, 8)) key_bytes.insert(key_bytes.size(), 8'($urandom()));
			end
			default: ;
		endcase
	endfunction

	initial begin
		int          sent;
		logic [14:0] sel_value;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed keys, every item reported.
		write_select(SEL_RESET);
		key_bytes = '{TC_MINKEY, TC_NULL, TC_OBJECT, TC_MAXKEY};
		send_key();
		// Escaped zero inside a string, string closed by a zero on the last byte.
		key_bytes = '{TC_STRING, 8'h41, 8'h00, ESC_BYTE, 8'h00};
		send_key();
		// Unknown type code after a complete item.
		key_bytes = '{TC_BOOL, 8'h01, 8'hFA};
		send_key();
		// Unterminated packed array.
		key_bytes = '{TC_PARRAY, 8'h07};
		send_key();
		// Number cut off by the key end.
		key_bytes = '{TC_NUMBER, 8'h00, 8'hFF};
		send_key();
		// Binary of zero length, then one with a length far beyond the key.
		key_bytes = '{TC_BINARY, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5A};
		send_key();
		key_bytes = '{TC_BINARY, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_key();

		// Random keys under several select settings, the extremes among them.
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			case (ph)
				0:       sel_value = SEL_RESET;
				1:       sel_value = 15'd0;
				2:       sel_value = 15'd1;
				3:       sel_value = 15'd16383;
				4:       sel_value = 15'd2;
				default: sel_value = $urandom_range(0, 1) ? SEL_RESET : 15'($urandom_range(0, 4));
			endcase
			write_select(sel_value);
			sent = 0;
			while (sent < RANDOM_BYTES / PHASE_COUNT) begin
				make_random_key();
				send_key();
				sent += key_bytes.size();
			end
		end

		drain();
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
